@@ hdl/upe_pkg.sv @@
// upe_pkg: shared types, constants and character-class functions for the
// URL percent encoder. No dependencies.

package upe_pkg;

	// Encode modes held in the mode register
	localparam logic [1:0] MODE_PLAIN      = 2'd0;
	localparam logic [1:0] MODE_RESERVED   = 2'd1;
	localparam logic [1:0] MODE_FORM       = 2'd2;
	localparam logic [1:0] MODE_FORM_RSVD  = 2'd3;

	// Output slots of one command: "%25" for a held percent, the held digit,
	// then the current byte as itself or as "%HH".
	localparam int SLOT_COUNT = 7;
	localparam logic [2:0] SLOT_PCT    = 3'd0;
	localparam logic [2:0] SLOT_TWO    = 3'd1;
	localparam logic [2:0] SLOT_FIVE   = 3'd2;
	localparam logic [2:0] SLOT_DIGIT  = 3'd3;
	localparam logic [2:0] SLOT_CUR    = 3'd4;
	localparam logic [2:0] SLOT_HEX_HI = 3'd5;
	localparam logic [2:0] SLOT_HEX_LO = 3'd6;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// One unit of work passed from the front to the back
	typedef struct packed {
		logic [SLOT_COUNT-1:0] mask;
		logic [7:0]            digit;
		logic [7:0]            cur;
		logic                  last;
	} cmd_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
			((c >= 8'h61) && (c <= 8'h66));
	endfunction

	function automatic logic is_rsvd_char(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D,
			8'h40, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
			8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic passes(input logic [1:0] mode, input logic [7:0] c);
		logic base;
		logic std_unres;
		logic form_unres;
		logic r;
		base       = is_alnum(c) || (c == CH_DASH) || (c == CH_DOT) || (c == CH_UNDER);
		std_unres  = base || (c == CH_TILDE);
		form_unres = base || (c == CH_STAR);
		unique case (mode)
			MODE_PLAIN:    r = std_unres;
			MODE_RESERVED: r = std_unres || is_rsvd_char(c);
			MODE_FORM:     r = form_unres;
			default:       r = !((c == CH_AMP) || (c == CH_EQ) || (c == CH_PLUS)) &&
				(form_unres || is_rsvd_char(c));
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

endpackage

@@ hdl/upe_front.sv @@
// upe_front: accepts raw bytes, tracks a held '%' and hex digit, and turns
// each byte that is not held into a slot-mask command. Depends on upe_pkg.

module upe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      mode,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            push,
	output upe_pkg::cmd_t   push_cmd,
	output logic [1:0]      held_cnt
);

	logic [1:0] held_cnt_q;
	logic [7:0] digit_q;
	logic [1:0] cnt_nxt;
	logic       hold_digit;
	logic       trip;
	logic       hex;
	logic       do_cur;
	upe_pkg::cmd_t cmd;

	assign trip     = mode[0];
	assign hex      = upe_pkg::is_hex(in_byte);
	assign held_cnt = held_cnt_q;

	always_comb begin
		cmd        = '0;
		cmd.digit  = digit_q;
		cmd.cur    = in_byte;
		cmd.last   = in_last;
		cnt_nxt    = 2'd0;
		hold_digit = 1'b0;
		do_cur     = 1'b1;

		case (held_cnt_q)
			2'd2: begin
				if (trip && hex) begin
					// completed triplet: pass all three bytes as they are
					cmd.mask[upe_pkg::SLOT_PCT]   = 1'b1;
					cmd.mask[upe_pkg::SLOT_DIGIT] = 1'b1;
					cmd.mask[upe_pkg::SLOT_CUR]   = 1'b1;
					do_cur = 1'b0;
				end else begin
					cmd.mask[upe_pkg::SLOT_PCT]   = 1'b1;
					cmd.mask[upe_pkg::SLOT_TWO]   = 1'b1;
					cmd.mask[upe_pkg::SLOT_FIVE]  = 1'b1;
					cmd.mask[upe_pkg::SLOT_DIGIT] = 1'b1;
				end
			end
			2'd1: begin
				if (trip && hex && !in_last) begin
					hold_digit = 1'b1;
					cnt_nxt    = 2'd2;
					do_cur     = 1'b0;
				end else begin
					cmd.mask[upe_pkg::SLOT_PCT]  = 1'b1;
					cmd.mask[upe_pkg::SLOT_TWO]  = 1'b1;
					cmd.mask[upe_pkg::SLOT_FIVE] = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_cur) begin
			if (trip && (in_byte == upe_pkg::CH_PCT) && !in_last) begin
				cnt_nxt = 2'd1;
			end else if (mode[1] && (in_byte == upe_pkg::CH_SPACE)) begin
				cmd.cur = upe_pkg::CH_PLUS;
				cmd.mask[upe_pkg::SLOT_CUR] = 1'b1;
			end else if (upe_pkg::passes(mode, in_byte)) begin
				cmd.mask[upe_pkg::SLOT_CUR] = 1'b1;
			end else begin
				cmd.mask[upe_pkg::SLOT_CUR]    = 1'b1;
				cmd.mask[upe_pkg::SLOT_HEX_HI] = 1'b1;
				cmd.mask[upe_pkg::SLOT_HEX_LO] = 1'b1;
			end
		end
	end

	assign push     = accept && (cmd.mask != '0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_digit) begin
			digit_q <= in_byte;
		end
	end

endmodule

@@ hdl/upe_queue.sv @@
// upe_queue: small command queue between front and back.
// Depends on upe_pkg.

module upe_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upe_pkg::cmd_t push_cmd,
	input  logic          pop,
	output upe_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	upe_pkg::cmd_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hdl/upe_back.sv @@
// upe_back: walks the slot mask of each command and drives one encoded byte
// per cycle, while the output is not stalled, into the output register. Depends on upe_pkg.

module upe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  upe_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [upe_pkg::SLOT_COUNT-1:0] rem
);

	upe_pkg::cmd_t cmd_q;
	logic [upe_pkg::SLOT_COUNT-1:0] rem_q;
	logic [upe_pkg::SLOT_COUNT-1:0] rem_nxt;
	logic [2:0] sel;
	logic       advance;
	logic [7:0] byte_sel;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_valid_q;

	always_comb begin
		sel = 3'd0;
		for (int i = upe_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				sel = 3'(i);
			end
		end
	end

	assign rem_nxt = rem_q & ~(upe_pkg::SLOT_COUNT'(1) << sel);
	assign advance = (rem_q != '0) && (!out_valid_q || out_ready);
	assign pop     = !empty && ((rem_q == '0) || (advance && (rem_nxt == '0)));
	assign rem     = rem_q;

	always_comb begin
		unique case (sel)
			upe_pkg::SLOT_PCT:    byte_sel = upe_pkg::CH_PCT;
			upe_pkg::SLOT_TWO:    byte_sel = upe_pkg::CH_TWO;
			upe_pkg::SLOT_FIVE:   byte_sel = upe_pkg::CH_FIVE;
			upe_pkg::SLOT_DIGIT:  byte_sel = cmd_q.digit;
			upe_pkg::SLOT_CUR:    byte_sel = cmd_q.mask[upe_pkg::SLOT_HEX_HI] ?
				upe_pkg::CH_PCT : cmd_q.cur;
			upe_pkg::SLOT_HEX_HI: byte_sel = upe_pkg::hex_char(cmd_q.cur[7:4]);
			upe_pkg::SLOT_HEX_LO: byte_sel = upe_pkg::hex_char(cmd_q.cur[3:0]);
			default:              byte_sel = upe_pkg::CH_PCT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= head.mask;
			end else if (advance) begin
				rem_q <= rem_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (advance) begin
			out_byte_q <= byte_sel;
			out_last_q <= cmd_q.last && (rem_nxt == '0);
		end
	end

	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

endmodule

@@ hdl/url_percent_encoder.sv @@
// url_percent_encoder: top level of the percent encoder; holds the mode
// register and joins front, command queue and back. Depends on upe_pkg.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    in_byte[7:0], in_last
//   output    out        out_valid / out_ready  out_byte[7:0], out_last
//   config    in         cfg_we (no wait)       cfg_wdata[1:0] -> encode mode
//
// The back emits one encoded byte per cycle unless the output stalls. An input
// byte gives one output byte (passed) or three (escaped), and up to seven when a
// held '%' and digit are flushed ahead of it. Held bytes give no output bytes.
// The front takes a byte every cycle while the command queue has room; the
// queue lets the front keep classifying while the back drains a long escape.
// arst_n clears the mode to plain, the held count, the queue and the output
// valid flag. A stalled output holds its byte; the back stops, the queue fills
// and then in_ready drops.

module url_percent_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	logic [1:0]    mode_q;
	logic          accept;
	logic          push;
	logic          pop;
	logic          empty;
	logic          full;
	logic [1:0]    held_cnt;
	upe_pkg::cmd_t push_cmd;
	upe_pkg::cmd_t head;
	logic [upe_pkg::SLOT_COUNT-1:0] rem;

	// mode register, written only while the block is idle: a rule for the user that the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= upe_pkg::MODE_PLAIN;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// take a byte whenever the queue can hold its command
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	upe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.push_cmd (push_cmd),
		.held_cnt (held_cnt)
	);

	upe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	upe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rem       (rem)
	);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into full queue");

	// at most a '%' and one digit are ever held
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt != 2'd3)
		else $error("held count out of range");

	// an escaped byte always carries both hex slots, "%25" both trailing digits
	a_mask_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_cmd.mask[upe_pkg::SLOT_HEX_HI] == push_cmd.mask[upe_pkg::SLOT_HEX_LO]) &&
			(push_cmd.mask[upe_pkg::SLOT_TWO] == push_cmd.mask[upe_pkg::SLOT_FIVE]))
		else $error("malformed slot mask");

	// a pending hex-high slot is never left without its hex-low slot
	a_rem_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rem[upe_pkg::SLOT_HEX_HI] |-> rem[upe_pkg::SLOT_HEX_LO])
		else $error("hex slot order broken");

endmodule

@@ sim/upe_encoding_check.sv @@
// upe_encoding_check: watches the input, output and mode-register ports of the
// URL percent encoder, predicts the encoded bytes and compares them.
// Depends on upe_pkg for the mode codes and character constants.

module upe_encoding_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	output int         fail_count,
	output int         backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	enc_char_t  chars_due[$];
	logic [1:0] enc_mode = upe_pkg::MODE_PLAIN;
	int         held_n = 0;
	logic [7:0] held_pct = '0;
	logic [7:0] held_digit = '0;
	logic [7:0] step_chars [0:6];
	int         step_n;

	initial fail_count = 0;
	initial backlog = 0;

	function automatic logic hex_digit_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
			(c >= "a" && c <= "f");
	endfunction

	function automatic logic rfc_reserved(input logic [7:0] c);
		case (c)
			":", "/", "?", "#", "[", "]", "@", "!", "$",
			"&", "'", "(", ")", "*", "+", ",", ";", "=": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic goes_through(input logic [1:0] mode, input logic [7:0] c);
		logic core;
		core = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == upe_pkg::CH_DASH ||
			c == upe_pkg::CH_DOT || c == upe_pkg::CH_UNDER;
		case (mode)
			upe_pkg::MODE_PLAIN:    return core || c == upe_pkg::CH_TILDE;
			upe_pkg::MODE_RESERVED: return core || c == upe_pkg::CH_TILDE || rfc_reserved(c);
			upe_pkg::MODE_FORM:     return core || c == upe_pkg::CH_STAR;
			default: begin
				if (c == upe_pkg::CH_AMP || c == upe_pkg::CH_EQ || c == upe_pkg::CH_PLUS)
					return 1'b0;
				return core || c == upe_pkg::CH_STAR || rfc_reserved(c);
			end
		endcase
	endfunction

	function automatic logic [7:0] hex_glyph(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h41 + {4'd0, n - 4'd10});
	endfunction

	function automatic void add_char(input logic [7:0] c);
		step_chars[step_n] = c;
		step_n++;
	endfunction

	// Encode one byte alone under the current mode
	function automatic void escape_one(input logic [7:0] c);
		if (enc_mode[1] && c == upe_pkg::CH_SPACE) begin
			add_char(upe_pkg::CH_PLUS);
		end else if (goes_through(enc_mode, c)) begin
			add_char(c);
		end else begin
			add_char(upe_pkg::CH_PCT);
			add_char(hex_glyph(c[7:4]));
			add_char(hex_glyph(c[3:0]));
		end
	endfunction

	function automatic void predict_encoding(input logic [7:0] c, input logic last);
		logic triplets;
		logic done;
		enc_char_t e;
		triplets = enc_mode[0];
		done = 1'b0;
		step_n = 0;
		if (held_n == 2) begin
			if (triplets && hex_digit_char(c)) begin
				add_char(held_pct);
				add_char(held_digit);
				add_char(c);
				done = 1'b1;
			end else begin
				escape_one(held_pct);
				escape_one(held_digit);
			end
			held_n = 0;
		end else if (held_n == 1) begin
			if (triplets && hex_digit_char(c) && !last) begin
				held_digit = c;
				held_n = 2;
				return;
			end
			escape_one(held_pct);
			held_n = 0;
		end
		if (!done) begin
			if (triplets && c == upe_pkg::CH_PCT && !last) begin
				held_pct = c;
				held_n = 1;
			end else begin
				escape_one(c);
			end
		end
		for (int i = 0; i < step_n; i++) begin
			e.ch = step_chars[i];
			e.last = last && (i == step_n - 1);
			chars_due.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			enc_mode = upe_pkg::MODE_PLAIN;
			held_n = 0;
			chars_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (chars_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR %0t: unexpected output byte %02h last %0b",
							$time, out_byte, out_last);
				end else begin
					want = chars_due.pop_front();
					if (out_byte !== want.ch || out_last !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR %0t: expected byte %02h last %0b, got byte %02h last %0b",
								$time, want.ch, want.last, out_byte, out_last);
					end
				end
			end
			if (cfg_we)
				enc_mode = cfg_wdata;
			if (in_valid && in_ready)
				predict_encoding(in_byte, in_last);
		end
		backlog = chars_due.size();
	end

endmodule

@@ sim/testbench.sv @@
// testbench: drives strings into the URL percent encoder under all four modes
// and gives the verdict. Depends on upe_pkg, url_percent_encoder and
// upe_encoding_check.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = '0;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = upe_pkg::MODE_PLAIN;

	int fail_count;
	int backlog;

	// Gap control for both sides; the hold request asks the receiver for one
	// long stall that it times by itself.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit rx_hold_req = 1'b0;

	// Bytes of the string being built, sent in one go
	logic [7:0] text_buf[$];

	url_percent_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	upe_encoding_check encoding_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop: a few times the slowest legal run (every byte escaped behind
	// a held pair, long stalls on both sides, the long hold-off).
	initial begin
		#5_000_000;
		$display("url_percent_encoder verification failed");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: decide out_ready once per falling edge. Exactly one
	// assignment per edge, so the ready level never glitches within a step.
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				hold_left = 300;
				rx_hold_req = 1'b0;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (rx_gaps)
					stall_left = pick_gap();
			end
		end
	end

	// Offer one byte and hold it until the transaction completes. Called and
	// returns at a falling edge; the caller lowers in_valid if nothing follows.
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		in_last  <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Send the buffered bytes; mark the final one as end of string if asked
	task automatic flush_text(input bit close);
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], close && (i == text_buf.size() - 1));
		text_buf.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	// Drop valid and wait until every predicted byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (backlog != 0)
			@(negedge clk);
	endtask

	// Write the mode only when idle; held bytes give no output, so wait on past
	// the drain to let the block settle after the last byte.
	task automatic set_mode(input logic [1:0] m);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_hex();
		int n;
		n = $urandom_range(0, 21);
		if (n < 10)
			return 8'(8'h30 + n);
		if (n < 16)
			return 8'(8'h41 + (n - 10));
		return 8'(8'h61 + (n - 16));
	endfunction

	function automatic logic [7:0] pick_plain();
		string marks;
		int n;
		marks = "-._~*";
		n = $urandom_range(0, 66);
		if (n < 26)
			return 8'(8'h61 + n);
		if (n < 52)
			return 8'(8'h41 + (n - 26));
		if (n < 62)
			return 8'(8'h30 + (n - 52));
		return marks[n - 62];
	endfunction

	function automatic logic [7:0] pick_reserved();
		string rsv;
		rsv = ":/?#[]@!$&'()*+,;=";
		return rsv[$urandom_range(0, rsv.len() - 1)];
	endfunction

	// Build a random string: mostly ordinary text and well-formed %HH
	// triplets, with broken escapes and arbitrary bytes mixed in.
	task automatic build_text();
		int len;
		int r;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				text_buf.push_back(pick_plain());
			end else if (r < 45) begin
				text_buf.push_back(pick_reserved());
			end else if (r < 52) begin
				text_buf.push_back(upe_pkg::CH_SPACE);
			end else if (r < 70) begin
				text_buf.push_back(upe_pkg::CH_PCT);
				text_buf.push_back(pick_hex());
				text_buf.push_back(pick_hex());
			end else if (r < 80) begin
				// broken escape: percent followed by a hex digit and junk,
				// by junk, or by another percent
				text_buf.push_back(upe_pkg::CH_PCT);
				case ($urandom_range(0, 2))
					0: begin
						text_buf.push_back(pick_hex());
						text_buf.push_back(pick_reserved());
					end
					1: text_buf.push_back(8'(8'h67 + $urandom_range(0, 19)));
					default: text_buf.push_back(upe_pkg::CH_PCT);
				endcase
			end else begin
				text_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		int sent_in_phase;
		logic [1:0] m;

		// Hold reset, then release it away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: byte extremes, tilde, space and a lone percent at end of
		// string in plain mode
		set_mode(upe_pkg::MODE_PLAIN);
		text_buf.push_back(8'h00);
		text_buf.push_back(8'hFF);
		push_text("~ %");
		flush_text(1'b1);

		// Allow-reserved: a completed triplet with lowercase hex, a triplet
		// broken after its digit, a doubled percent, a broken one, then a
		// held pair flushed ahead of an escaped space (seven bytes out),
		// and a percent that ends the string
		set_mode(upe_pkg::MODE_RESERVED);
		push_text("%4a%4g%%q%4 ");
		flush_text(1'b1);
		push_text("%");
		flush_text(1'b1);

		// Form allow-reserved: space to plus, ampersand and tilde escaped,
		// then leave a percent and a digit held across a mode change
		set_mode(upe_pkg::MODE_FORM_RSVD);
		push_text(" &~%B");
		flush_text(1'b0);

		// Form: the held pair is flushed under the new mode
		set_mode(upe_pkg::MODE_FORM);
		push_text("*c");
		flush_text(1'b1);

		// Random phases: all four modes in turn first, then random ones
		for (int ph = 0; ph < 8; ph++) begin
			m = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
			set_mode(m);
			rx_gaps = (ph != 5);
			// Long receiver hold-off while the sender keeps offering, so the
			// queue fills and in_ready drops
			if (ph == 2)
				rx_hold_req = 1'b1;
			sent_in_phase = 0;
			while (sent_in_phase < 42) begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				build_text();
				sent_in_phase += text_buf.size();
				flush_text(1'b1);
				// Now and then pause the sender until all output is out
				if (ph == 4 && $urandom_range(0, 3) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("url_percent_encoder verification clean");
		else
			$display("url_percent_encoder verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/upe_pkg.sv
hdl/upe_front.sv
hdl/upe_queue.sv
hdl/upe_back.sv
hdl/url_percent_encoder.sv
sim/upe_encoding_check.sv
sim/testbench.sv
